// ===== rtl/utf8_decode_text_cursor_macros.svh =====
// Assertion helpers for the cursor RTL.
`ifndef UTF8_DECODE_TEXT_CURSOR_MACROS_SVH
`define UTF8_DECODE_TEXT_CURSOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U8DC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("u8dc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define U8DC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("u8dc: next-cycle check failed");

`endif

// ===== rtl/u8dc_pkg.sv =====
package u8dc_pkg;

  // Default counter width for column, row and widest line.
  localparam int unsigned DefCountBits = 16;

  localparam int unsigned CpBits  = 21;
  localparam int unsigned OutBits = 16;

  localparam logic [CpBits-1:0] CpReplacement = 21'h00FFFD;
  localparam logic [CpBits-1:0] CpLineFeed    = 21'h00000A;
  localparam logic [CpBits-1:0] CpSpace       = 21'h000020;
  localparam logic [7:0]        ByteLineFeed  = 8'h0A;

  typedef enum logic {
    KIND_CHAR  = 1'b0,
    KIND_BREAK = 1'b1
  } item_kind_e;

  // One result word.
  typedef struct packed {
    logic [CpBits-1:0]  code_point;
    item_kind_e         item_kind;
    logic [OutBits-1:0] column;
    logic [OutBits-1:0] row;
    logic               is_space;
    logic [OutBits-1:0] widest_line;
    logic               last_result;
  } result_t;

endpackage

// ===== rtl/u8dc_step.sv =====
module u8dc_step
  import u8dc_pkg::*;
#(
  parameter int unsigned COUNT_BITS = DefCountBits
) (
  input  logic [7:0]            text_byte_i,
  input  logic                  end_of_text_i,
  input  logic [CpBits-1:0]     partial_i,
  input  logic [1:0]            remain_i,
  input  logic [COUNT_BITS-1:0] col_i,
  input  logic [COUNT_BITS-1:0] row_i,
  input  logic [COUNT_BITS-1:0] wide_i,
  output logic [CpBits-1:0]     partial_o,
  output logic [1:0]            remain_o,
  output logic [COUNT_BITS-1:0] col_o,
  output logic [COUNT_BITS-1:0] row_o,
  output logic [COUNT_BITS-1:0] wide_o,
  output logic                  first_valid_o,
  output logic                  second_valid_o,
  output result_t               first_o,
  output result_t               second_o
);

  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  logic                  is_cont;
  logic [CpBits-1:0]     cont_code;
  logic [1:0]            cont_remain;
  logic                  use_a;
  logic [CpBits-1:0]     cp_a;
  logic                  do_lead;
  logic                  lead_break;
  logic                  lead_char;
  logic                  lead_start;
  logic [CpBits-1:0]     lead_cp;
  logic [CpBits-1:0]     lead_partial;
  logic [1:0]            lead_remain;
  logic [COUNT_BITS-1:0] col_a;
  logic [COUNT_BITS-1:0] wide_a;
  logic [COUNT_BITS-1:0] col_b;
  logic [COUNT_BITS-1:0] row_b;
  logic [COUNT_BITS-1:0] wide_b;
  logic                  lead_emit;
  result_t               res_a;
  result_t               res_b;

  // Classify the byte as continuation or lead.
  always_comb begin
    is_cont     = (text_byte_i[7:6] == 2'b10);
    cont_code   = {partial_i[CpBits-7:0], text_byte_i[5:0]};
    cont_remain = remain_i - 2'd1;

    use_a = (remain_i != 2'd0) && (!is_cont || (cont_remain == 2'd0) || end_of_text_i);
    cp_a  = (is_cont && (cont_remain == 2'd0)) ? cont_code : CpReplacement;
    do_lead = (remain_i == 2'd0) || !is_cont;

    lead_break   = 1'b0;
    lead_char    = 1'b0;
    lead_start   = 1'b0;
    lead_cp      = CpReplacement;
    lead_partial = '0;
    lead_remain  = 2'd0;
    priority if (text_byte_i == ByteLineFeed) begin
      lead_break = 1'b1;
    end else if (!text_byte_i[7]) begin
      lead_char = 1'b1;
      lead_cp   = CpBits'(text_byte_i);
    end else if (text_byte_i[7:5] == 3'b110) begin
      lead_start   = 1'b1;
      lead_partial = CpBits'(text_byte_i[4:0]);
      lead_remain  = 2'd1;
    end else if (text_byte_i[7:4] == 4'b1110) begin
      lead_start   = 1'b1;
      lead_partial = CpBits'(text_byte_i[3:0]);
      lead_remain  = 2'd2;
    end else if (text_byte_i[7:3] == 5'b11110) begin
      lead_start   = 1'b1;
      lead_partial = CpBits'(text_byte_i[2:0]);
      lead_remain  = 2'd3;
    end else begin
      lead_char = 1'b1;
    end
    // A sequence opened by the final byte turns into a replacement cell.
    if (lead_start && end_of_text_i) begin
      lead_char = 1'b1;
      lead_cp   = CpReplacement;
    end
    lead_emit = do_lead && (lead_break || lead_char);
  end

  // Advance the counters through the first and then the second result.
  always_comb begin
    col_a  = col_i;
    wide_a = wide_i;
    if (use_a) begin
      col_a  = (col_i == CountMax) ? col_i : col_i + 1'b1;
      wide_a = (col_a > wide_i) ? col_a : wide_i;
    end

    col_b  = col_a;
    row_b  = row_i;
    wide_b = wide_a;
    res_b  = '0;
    res_b.row = OutBits'(row_i);
    if (lead_emit && lead_break) begin
      wide_b = (col_a > wide_a) ? col_a : wide_a;
      col_b  = '0;
      row_b  = (row_i == CountMax) ? row_i : row_i + 1'b1;
      res_b.code_point = CpLineFeed;
      res_b.item_kind  = KIND_BREAK;
      res_b.column     = OutBits'(col_a);
    end else if (lead_emit) begin
      col_b  = (col_a == CountMax) ? col_a : col_a + 1'b1;
      wide_b = (col_b > wide_a) ? col_b : wide_a;
      res_b.code_point = lead_cp;
      res_b.item_kind  = KIND_CHAR;
      res_b.column     = OutBits'(col_a);
      res_b.is_space   = (lead_cp == CpSpace);
    end
    res_b.widest_line = OutBits'(wide_b);
    res_b.last_result = end_of_text_i;

    res_a.code_point  = cp_a;
    res_a.item_kind   = KIND_CHAR;
    res_a.column      = OutBits'(col_i);
    res_a.row         = OutBits'(row_i);
    res_a.is_space    = (cp_a == CpSpace);
    res_a.widest_line = OutBits'(wide_a);
    res_a.last_result = end_of_text_i && !lead_emit;
  end

  // Order the results and pick the next state.
  always_comb begin
    first_valid_o  = use_a || lead_emit;
    second_valid_o = use_a && lead_emit;
    first_o        = use_a ? res_a : res_b;
    second_o       = res_b;

    partial_o = '0;
    remain_o  = 2'd0;
    if (!end_of_text_i) begin
      if ((remain_i != 2'd0) && is_cont && (cont_remain != 2'd0)) begin
        partial_o = cont_code;
        remain_o  = cont_remain;
      end else if (do_lead && lead_start) begin
        partial_o = lead_partial;
        remain_o  = lead_remain;
      end
    end

    if (end_of_text_i) begin
      col_o  = '0;
      row_o  = '0;
      wide_o = '0;
    end else begin
      col_o  = col_b;
      row_o  = row_b;
      wide_o = wide_b;
    end
  end

endmodule

// ===== rtl/utf8_decode_text_cursor.sv =====
// An accepted byte's first result word is registered and appears on the output in the cycle after it is taken.
// Throughput: one byte per cycle while the output is not stalled; a byte that yields two results
// (a broken sequence followed by a new lead) holds the input while the second drains.
// The decode and counter update for a byte is one pass of logic into the result register.
// Reset clears the decoder state, all counters and the output and pending valid flags.
`include "utf8_decode_text_cursor_macros.svh"

module utf8_decode_text_cursor
  import u8dc_pkg::*;
#(
  parameter int unsigned COUNT_BITS = DefCountBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] text_byte
  input  logic        s_axis_tlast,  // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [20:0] code_point, [36:21] column, [52:37] row, [53] is_space,
  // [69:54] widest_line, [71:70] zero
  output logic [71:0] m_axis_tdata,
  output logic        m_axis_tuser,  // item_kind
  output logic        m_axis_tlast   // last_result
);

  logic [CpBits-1:0]     partial_q, partial_d;
  logic [1:0]            remain_q, remain_d;
  logic [COUNT_BITS-1:0] col_q, col_d;
  logic [COUNT_BITS-1:0] row_q, row_d;
  logic [COUNT_BITS-1:0] wide_q, wide_d;
  logic                  out_valid_q, out_valid_d;
  logic                  pend_valid_q, pend_valid_d;
  result_t               out_q, out_d;
  result_t               pend_q, pend_d;
  logic                  first_valid, second_valid;
  result_t               first_res, second_res;
  logic                  out_free;
  logic                  in_acc;

  // Decode one byte against the current state.
  u8dc_step #(
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .text_byte_i   (s_axis_tdata),
    .end_of_text_i (s_axis_tlast),
    .partial_i     (partial_q),
    .remain_i      (remain_q),
    .col_i         (col_q),
    .row_i         (row_q),
    .wide_i        (wide_q),
    .partial_o     (partial_d),
    .remain_o      (remain_d),
    .col_o         (col_d),
    .row_o         (row_d),
    .wide_o        (wide_d),
    .first_valid_o (first_valid),
    .second_valid_o(second_valid),
    .first_o       (first_res),
    .second_o      (second_res)
  );

  // Accept a byte whenever the result register frees up and nothing is pending.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = out_free && !pend_valid_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Steer results into the output and pending registers.
  always_comb begin
    out_valid_d  = out_valid_q;
    pend_valid_d = pend_valid_q;
    out_d        = out_q;
    pend_d       = pend_q;
    if (pend_valid_q && out_free) begin
      out_d        = pend_q;
      out_valid_d  = 1'b1;
      pend_valid_d = 1'b0;
    end else if (in_acc) begin
      out_d        = first_res;
      out_valid_d  = first_valid;
      pend_d       = second_res;
      pend_valid_d = second_valid;
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
  end

  // Hold decoder state and output control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q    <= '0;
      remain_q     <= 2'd0;
      col_q        <= '0;
      row_q        <= '0;
      wide_q       <= '0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        partial_q <= partial_d;
        remain_q  <= remain_d;
        col_q     <= col_d;
        row_q     <= row_d;
        wide_q    <= wide_d;
      end
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.widest_line, out_q.is_space, out_q.row,
                          out_q.column, out_q.code_point};
  assign m_axis_tuser  = out_q.item_kind;
  assign m_axis_tlast  = out_q.last_result;

  // A pending word always sits behind a valid output word.
  `U8DC_ASSERT_NOW(a_pend_behind_out, clk_i, rst_ni, pend_valid_q, out_valid_q)
  // No byte is taken while a second result waits.
  `U8DC_ASSERT_NOW(a_no_accept_pend, clk_i, rst_ni, pend_valid_q, !s_axis_tready)
  // A stalled pending word is not lost.
  `U8DC_ASSERT_NEXT(a_pend_kept, clk_i, rst_ni, pend_valid_q && !m_axis_tready,
                    pend_valid_q)
  // End of text returns the decoder and counters to their reset state.
  `U8DC_ASSERT_NEXT(a_end_clears, clk_i, rst_ni, in_acc && s_axis_tlast,
                    (remain_q == 2'd0) && (col_q == '0) && (row_q == '0))

endmodule
